[src/ddmcp_pkg.sv]
package ddmcp_pkg;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W = 32;

  localparam int IN_FIELDS_W = 1 + ADDR_W + DATA_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + 2 + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int DEF_MEM_WORDS = 65536;
  localparam int DEF_LINE_WORDS_A = 4;
  localparam int DEF_LINES_A = 256;
  localparam int DEF_LINE_WORDS_B = 8;
  localparam int DEF_LINES_B = 128;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

endpackage

[src/ddmcp_tag_unit.sv]
module ddmcp_tag_unit #(
  parameter int LINE_WORDS = ddmcp_pkg::DEF_LINE_WORDS_A,
  parameter int LINES = ddmcp_pkg::DEF_LINES_A
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [ddmcp_pkg::ADDR_W-1:0] address,
  output logic                      ready,
  output logic                      hit
);
  import ddmcp_pkg::*;

  localparam int OW = $clog2(LINE_WORDS);
  localparam int IW_REAL = $clog2(LINES);
  localparam int IW = (IW_REAL > 0) ? IW_REAL : 1;
  localparam int TW = (ADDR_W > OW + IW_REAL) ? ADDR_W - OW - IW_REAL : 1;

  logic [ADDR_W-1:0] line;
  logic [IW-1:0]     idx;
  logic [TW-1:0]     tag;

  logic [TW:0]       mem [LINES];
  logic [TW:0]       entry;
  logic [TW-1:0]     tag_q;

  logic              clr_busy;
  logic [IW-1:0]     clr_idx;

  assign line = address >> OW;
  assign idx = IW'(line % LINES);
  assign tag = TW'(line >> IW_REAL);
  assign ready = !clr_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + IW'(1);
      if (clr_idx == IW'(LINES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // allocate on every access: a hit rewrites the same tag
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_idx] <= '0;
    end else if (en) begin
      mem[idx] <= {1'b1, tag};
    end
    if (en) begin
      entry <= mem[idx];
      tag_q <= tag;
    end
  end

  assign hit = entry[TW] && (entry[TW-1:0] == tag_q);

endmodule

[src/ddmcp_word_mem.sv]
module ddmcp_word_mem #(
  parameter int MEM_WORDS = ddmcp_pkg::DEF_MEM_WORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  ddmcp_pkg::op_t               op,
  input  logic [ddmcp_pkg::ADDR_W-1:0] address,
  input  logic [ddmcp_pkg::DATA_W-1:0] write_data,
  output logic [ddmcp_pkg::DATA_W-1:0] read_data
);
  import ddmcp_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [DATA_W-1:0]    mem [MEM_WORDS];
  logic [DATA_W-1:0]    q;
  logic                 q_ok;
  logic [AW+ADDR_W-1:0] addr_ext;
  logic [AW-1:0]        idx;
  logic                 in_range;

  assign addr_ext = (AW + ADDR_W)'(address);
  assign idx = addr_ext[AW-1:0];
  assign in_range = 32'(address) < 32'(MEM_WORDS);

  always_ff @(posedge clk) begin
    if (en && in_range) begin
      if (op == OP_WRITE) begin
        mem[idx] <= write_data;
      end else begin
        q <= mem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ok <= 1'b0;
    end else if (en) begin
      q_ok <= in_range && (op == OP_READ);
    end
  end

  assign read_data = q_ok ? q : '0;

endmodule

[src/dual_direct_mapped_cache_profiler.sv]
// Channel   Dir  Width  Fields (lowest bit up)
// s_axis    in   56     operation[0], address[16:1], write_data[48:17]
// m_axis    out  136    read_data[31:0], hit_a[32], hit_b[33], access_total[65:34],
//                       hits_total_a[97:66], hits_total_b[129:98]
//
// One request per cycle sustained while m_axis_tready is high; a result is valid from the result register.
// The word memory is read or written, and both tag memories are read and written, at the accept edge;
// the stage register is loaded at that edge too, and the result register follows.
// After rst the tag memories are cleared, one line a cycle, until every line of both
// is cleared; s_axis_tready stays low meanwhile.
// A stalled result backs up through the stage register to s_axis_tready.
module dual_direct_mapped_cache_profiler #(
  parameter int MEM_WORDS = ddmcp_pkg::DEF_MEM_WORDS,
  parameter int LINE_WORDS_A = ddmcp_pkg::DEF_LINE_WORDS_A,
  parameter int LINES_A = ddmcp_pkg::DEF_LINES_A,
  parameter int LINE_WORDS_B = ddmcp_pkg::DEF_LINE_WORDS_B,
  parameter int LINES_B = ddmcp_pkg::DEF_LINES_B
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // operation, address, write_data
  input  logic [ddmcp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_data, hit_a, hit_b, access_total, hits_total_a, hits_total_b
  output logic [ddmcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ddmcp_pkg::*;

  op_t               in_op;
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_write_data;
  logic              accept;

  logic              ready_a;
  logic              ready_b;
  logic              probe_hit_a;
  logic              probe_hit_b;
  logic [DATA_W-1:0] read_data;

  logic              s1_valid;
  op_t               s1_op;
  logic              s1_move;

  logic              is_read;
  logic              hit_a;
  logic              hit_b;
  logic [CNT_W-1:0]  access_count;
  logic [CNT_W-1:0]  hit_count_a;
  logic [CNT_W-1:0]  hit_count_b;
  logic [CNT_W-1:0]  access_count_next;
  logic [CNT_W-1:0]  hit_count_a_next;
  logic [CNT_W-1:0]  hit_count_b_next;

  assign in_op = op_t'(s_axis_tdata[0]);
  assign in_address = s_axis_tdata[ADDR_W:1];
  assign in_write_data = s_axis_tdata[ADDR_W+DATA_W:ADDR_W+1];

  assign s1_move = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = ready_a && ready_b && (!s1_valid || s1_move);
  assign accept = s_axis_tvalid && s_axis_tready;

  ddmcp_word_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_word_mem (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .op         (in_op),
    .address    (in_address),
    .write_data (in_write_data),
    .read_data  (read_data)
  );

  ddmcp_tag_unit #(
    .LINE_WORDS (LINE_WORDS_A),
    .LINES      (LINES_A)
  ) u_tag_a (
    .clk     (clk),
    .rst     (rst),
    .en      (accept),
    .address (in_address),
    .ready   (ready_a),
    .hit     (probe_hit_a)
  );

  ddmcp_tag_unit #(
    .LINE_WORDS (LINE_WORDS_B),
    .LINES      (LINES_B)
  ) u_tag_b (
    .clk     (clk),
    .rst     (rst),
    .en      (accept),
    .address (in_address),
    .ready   (ready_b),
    .hit     (probe_hit_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= in_op;
    end
  end

  assign is_read = (s1_op == OP_READ);
  assign hit_a = is_read && probe_hit_a;
  assign hit_b = is_read && probe_hit_b;
  assign access_count_next = access_count + CNT_W'(is_read);
  assign hit_count_a_next = hit_count_a + CNT_W'(hit_a);
  assign hit_count_b_next = hit_count_b + CNT_W'(hit_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      access_count <= '0;
      hit_count_a <= '0;
      hit_count_b <= '0;
    end else if (s1_move) begin
      m_axis_tvalid <= 1'b1;
      access_count <= access_count_next;
      hit_count_a <= hit_count_a_next;
      hit_count_b <= hit_count_b_next;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tdata <= {OUT_PAD_W'(0), hit_count_b_next, hit_count_a_next,
                       access_count_next, hit_b, hit_a, read_data};
    end
  end

endmodule

[src/ddmcp_checker.sv]
module ddmcp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ddmcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ddmcp_pkg::*;

  logic             out_hs;
  logic             hit_a;
  logic             hit_b;
  logic [CNT_W-1:0] access_total;
  logic [CNT_W-1:0] hits_total_a;
  logic [CNT_W-1:0] hits_total_b;

  logic             seen;
  logic [CNT_W-1:0] prev_access;
  logic [CNT_W-1:0] prev_hits_a;
  logic [CNT_W-1:0] prev_hits_b;

  assign out_hs = m_axis_tvalid && m_axis_tready;
  assign hit_a = m_axis_tdata[DATA_W];
  assign hit_b = m_axis_tdata[DATA_W+1];
  assign access_total = m_axis_tdata[DATA_W+2+CNT_W-1:DATA_W+2];
  assign hits_total_a = m_axis_tdata[DATA_W+2+2*CNT_W-1:DATA_W+2+CNT_W];
  assign hits_total_b = m_axis_tdata[DATA_W+2+3*CNT_W-1:DATA_W+2+2*CNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
      prev_access <= '0;
      prev_hits_a <= '0;
      prev_hits_b <= '0;
    end else if (out_hs) begin
      seen <= 1'b1;
      prev_access <= access_total;
      prev_hits_a <= hits_total_a;
      prev_hits_b <= hits_total_b;
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("outputs not idle after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_hits_a_step: assert property (@(posedge clk) disable iff (rst)
    out_hs && seen |-> hits_total_a == prev_hits_a + CNT_W'(hit_a))
    else $error("hit count A out of step with hit flag");

  a_hits_b_step: assert property (@(posedge clk) disable iff (rst)
    out_hs && seen |-> hits_total_b == prev_hits_b + CNT_W'(hit_b))
    else $error("hit count B out of step with hit flag");

  a_access_step: assert property (@(posedge clk) disable iff (rst)
    out_hs && seen && (hit_a || hit_b) |-> access_total == prev_access + CNT_W'(1))
    else $error("hit reported without a counted read");

endmodule

bind dual_direct_mapped_cache_profiler ddmcp_checker u_ddmcp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
